// File: src/llmq_pkg.sv
// Shared types and constants for the linked-list multi-queue unit.
// No dependencies; imported by every module of the block.
package llmq_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int QUEUE_COUNT = 16;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int QUEUE_W     = $clog2(QUEUE_COUNT);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_QUEUED = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [QUEUE_W-1:0] queue_index;
    logic [NODE_W-1:0]  item_index;
  } llmq_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] pulled_item;
    logic [1:0]        status;
  } llmq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;  // one step of the post-reset clearing pass
    logic load;   // capture transaction, issue memory reads
    logic exec;   // commit pointer writes, load result register
  } llmq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is on its final entry
    logic out_free;    // result register can take a new result
  } llmq_sts_t;

endpackage

// File: src/llmq_ctrl.sv
// Sequencing controller for the linked-list multi-queue unit.
// Depends on llmq_pkg for the command and status structs.
module llmq_ctrl
  import llmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  llmq_sts_t sts,
  output llmq_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Commands
  assign in_ready  = (state == S_IDLE);
  assign cmd.clear = (state == S_CLEAR);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state == S_EXEC) && sts.out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/llmq_datapath.sv
// Node memories, queue pointer registers and result register.
// Depends on llmq_pkg; driven by llmq_ctrl through llmq_cmd_t.
module llmq_datapath
  import llmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  llmq_in_t  in_data,
  input  llmq_cmd_t cmd,
  output llmq_sts_t sts,
  output logic      out_valid,
  input  logic      out_ready,
  output llmq_out_t out_data
);

  // Node state: queued flag and link to the next newer node
  logic              queued_mem [NODE_COUNT];
  logic [NODE_W-1:0] newer_mem  [NODE_COUNT];

  // Per-queue head/tail pointers and occupancy flags
  logic [NODE_W-1:0]      queue_newest [QUEUE_COUNT];
  logic [NODE_W-1:0]      queue_oldest [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] queue_nonempty;

  logic [NODE_W-1:0] clear_cnt;
  llmq_in_t          req;
  logic              queued_rd;
  logic [NODE_W-1:0] newer_rd;

  logic              q_nonempty;
  logic [NODE_W-1:0] q_old;
  logic [NODE_W-1:0] q_new;
  logic              is_push;
  logic              push_ok;
  logic              pull_ok;
  logic              pull_last;
  logic              queued_we;
  logic [NODE_W-1:0] queued_addr;
  logic              queued_wd;
  logic              newer_we;

  assign sts.clear_last = (clear_cnt == NODE_W'(NODE_COUNT - 1));
  assign sts.out_free   = !out_valid || out_ready;

  // Decode of the held transaction
  assign q_nonempty = queue_nonempty[req.queue_index];
  assign q_old      = queue_oldest[req.queue_index];
  assign q_new      = queue_newest[req.queue_index];
  assign is_push    = (req.operation == OP_PUSH);
  assign push_ok    = is_push && !queued_rd;
  assign pull_ok    = !is_push && q_nonempty;
  assign pull_last  = (q_old == q_new);

  // Queued-flag write port: clearing pass, set on push, drop on pull
  assign queued_we   = cmd.clear || (cmd.exec && (push_ok || pull_ok));
  assign queued_addr = cmd.clear ? clear_cnt : (is_push ? req.item_index : q_old);
  assign queued_wd   = !cmd.clear && is_push;
  // Previous newest node gets linked forward to the pushed one
  assign newer_we    = cmd.exec && push_ok && q_nonempty;

  // Node memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (queued_we) queued_mem[queued_addr] <= queued_wd;
    if (newer_we) newer_mem[q_new] <= req.item_index;
    if (cmd.load) begin
      queued_rd <= queued_mem[in_data.item_index];
      newer_rd  <= newer_mem[queue_oldest[in_data.queue_index]];
    end
  end

  // Transaction capture and queue pointers
  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
    if (cmd.exec && push_ok) begin
      queue_newest[req.queue_index] <= req.item_index;
      if (!q_nonempty) queue_oldest[req.queue_index] <= req.item_index;
    end
    if (cmd.exec && pull_ok && !pull_last) begin
      queue_oldest[req.queue_index] <= newer_rd;
    end
    if (cmd.exec) begin
      out_data.pulled_item <= pull_ok ? q_old : '0;
      if (is_push) begin
        out_data.status <= queued_rd ? STAT_QUEUED : STAT_DONE;
      end else begin
        out_data.status <= q_nonempty ? STAT_DONE : STAT_EMPTY;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt      <= '0;
      queue_nonempty <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.clear) clear_cnt <= clear_cnt + 1'b1;
      if (cmd.exec && push_ok) queue_nonempty[req.queue_index] <= 1'b1;
      if (cmd.exec && pull_ok && pull_last) queue_nonempty[req.queue_index] <= 1'b0;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/linked_list_multi_queue_unit.sv
// Linked-list multi-queue unit: FIFO queues threaded through a shared node pool.
// Each transaction: the accept cycle reads the node's queued flag and the oldest
// node's forward link from single-port node memories; once the result register
// is free, the execute state writes the links and pointers and loads the result
// register. A new transaction is taken while the previous result still waits.
// After reset a clearing pass sweeps all NODE_COUNT (1024) queued flags, with
// in_ready low throughout. Depends on llmq_pkg, llmq_ctrl, llmq_datapath.
module linked_list_multi_queue_unit
  import llmq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  llmq_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output llmq_out_t out_data
);

  llmq_cmd_t cmd;
  llmq_sts_t sts;

  llmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  llmq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // One transaction in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("transaction accepted while previous still executing");

  // Clearing pass never overlaps a transaction
  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !in_ready && !cmd.exec)
    else $error("clearing pass overlaps a transaction");

  // A result is only committed when the result register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !out_valid || out_ready)
    else $error("result register overwritten");

  // Failed operations carry no node
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STAT_DONE) |-> out_data.pulled_item == '0)
    else $error("failed operation returned a node");

endmodule
